[rtl/text_readability_statistics_core_assert.svh]
// ----------------------------------------------------------------------------
// text readability statistics core: assertion macros
// concurrent checks on the clk / rst_n pair of the including module
// ----------------------------------------------------------------------------
`ifndef TEXT_READABILITY_STATISTICS_CORE_ASSERT_SVH
`define TEXT_READABILITY_STATISTICS_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define TRS_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define TRS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

[rtl/trs_pkg.sv]
// ----------------------------------------------------------------------------
// trs_pkg
// shared types, constants and the end-of-text sequencer program
// ----------------------------------------------------------------------------
`default_nettype none

package trs_pkg;

  localparam int CNT_W                 = 21;
  localparam int DEF_MAX_TEXT_BYTES    = 1048576;
  localparam int DEF_WORD_BUFFER_BYTES = 64;
  localparam int ACC_W                 = 64;
  localparam int MUL_A_W               = 2 * CNT_W;
  localparam int MUL_B_W               = CNT_W + 1;
  localparam int STEP_W                = 5;
  localparam int OUT_DATA_W            = 296;

  // step kinds
  localparam logic [2:0] K_MUL  = 3'd0;
  localparam logic [2:0] K_MAC  = 3'd1;
  localparam logic [2:0] K_MACF = 3'd2;
  localparam logic [2:0] K_DIV  = 3'd3;
  localparam logic [2:0] K_END  = 3'd4;

  // multiplier a operand / divisor select
  localparam logic [2:0] A_W   = 3'd0;
  localparam logic [2:0] A_S   = 3'd1;
  localparam logic [2:0] A_Y   = 3'd2;
  localparam logic [2:0] A_L   = 3'd3;
  localparam logic [2:0] A_WW  = 3'd4;
  localparam logic [2:0] A_YS  = 3'd5;
  localparam logic [2:0] A_DEN = 3'd6;

  // multiplier b operand select
  localparam logic [1:0] B_CONST = 2'd0;
  localparam logic [1:0] B_W     = 2'd1;
  localparam logic [1:0] B_S     = 2'd2;

  // destinations of product steps
  localparam logic [2:0] D_WW  = 3'd0;
  localparam logic [2:0] D_YS  = 3'd1;
  localparam logic [2:0] D_DEN = 3'd2;

  // destinations of quotient steps
  localparam logic [2:0] D_AVGLEN  = 3'd0;
  localparam logic [2:0] D_AVGSENT = 3'd1;
  localparam logic [2:0] D_AVGSYL  = 3'd2;
  localparam logic [2:0] D_EASE    = 3'd3;
  localparam logic [2:0] D_GRADE   = 3'd4;
  localparam logic [2:0] D_FOG     = 3'd5;

  typedef struct packed {
    logic [2:0]                 kind;
    logic [2:0]                 a_sel;
    logic [1:0]                 b_sel;
    logic                       clr;
    logic signed [MUL_B_W-1:0]  k;
    logic [2:0]                 dest;
  } ucode_t;

  typedef struct packed {
    logic   take;
    logic   close;
    logic   clear;
    logic   run;
    ucode_t uc;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  function automatic ucode_t trs_uc(input logic [2:0] kind, input logic [2:0] a_sel,
                                    input logic [1:0] b_sel, input logic clr,
                                    input logic signed [MUL_B_W-1:0] k,
                                    input logic [2:0] dest);
    ucode_t u;
    u.kind  = kind;
    u.a_sel = a_sel;
    u.b_sel = b_sel;
    u.clr   = clr;
    u.k     = k;
    u.dest  = dest;
    return u;
  endfunction

  // end-of-text program: products, numerators, then one division each
  function automatic ucode_t trs_ucode(input logic [STEP_W-1:0] step);
    ucode_t u;
    case (step)
      5'd0:  u = trs_uc(K_MUL,  A_W,   B_W,     1'b0, 22'sd0,       D_WW);
      5'd1:  u = trs_uc(K_MUL,  A_Y,   B_S,     1'b0, 22'sd0,       D_YS);
      5'd2:  u = trs_uc(K_MUL,  A_W,   B_S,     1'b0, 22'sd0,       D_DEN);
      5'd3:  u = trs_uc(K_MAC,  A_L,   B_CONST, 1'b1, 22'sd1000,    D_WW);
      5'd4:  u = trs_uc(K_DIV,  A_W,   B_CONST, 1'b0, 22'sd0,       D_AVGLEN);
      5'd5:  u = trs_uc(K_MAC,  A_W,   B_CONST, 1'b1, 22'sd1000,    D_WW);
      5'd6:  u = trs_uc(K_DIV,  A_S,   B_CONST, 1'b0, 22'sd0,       D_AVGSENT);
      5'd7:  u = trs_uc(K_MAC,  A_Y,   B_CONST, 1'b1, 22'sd1000,    D_WW);
      5'd8:  u = trs_uc(K_DIV,  A_W,   B_CONST, 1'b0, 22'sd0,       D_AVGSYL);
      5'd9:  u = trs_uc(K_MAC,  A_DEN, B_CONST, 1'b1, 22'sd206835,  D_WW);
      5'd10: u = trs_uc(K_MAC,  A_WW,  B_CONST, 1'b0, -22'sd1015,   D_WW);
      5'd11: u = trs_uc(K_MAC,  A_YS,  B_CONST, 1'b0, -22'sd84600,  D_WW);
      5'd12: u = trs_uc(K_DIV,  A_DEN, B_CONST, 1'b0, 22'sd0,       D_EASE);
      5'd13: u = trs_uc(K_MAC,  A_WW,  B_CONST, 1'b1, 22'sd390,     D_WW);
      5'd14: u = trs_uc(K_MAC,  A_YS,  B_CONST, 1'b0, 22'sd11800,   D_WW);
      5'd15: u = trs_uc(K_MAC,  A_DEN, B_CONST, 1'b0, -22'sd15590,  D_WW);
      5'd16: u = trs_uc(K_DIV,  A_DEN, B_CONST, 1'b0, 22'sd0,       D_GRADE);
      5'd17: u = trs_uc(K_MAC,  A_WW,  B_CONST, 1'b1, 22'sd400,     D_WW);
      5'd18: u = trs_uc(K_MACF, A_YS,  B_CONST, 1'b0, 22'sd12000,   D_WW);
      5'd19: u = trs_uc(K_MACF, A_DEN, B_CONST, 1'b0, -22'sd12000,  D_WW);
      5'd20: u = trs_uc(K_DIV,  A_DEN, B_CONST, 1'b0, 22'sd0,       D_FOG);
      default: u = trs_uc(K_END, A_W,  B_CONST, 1'b0, 22'sd0,       D_WW);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

[rtl/trs_div.sv]
// ----------------------------------------------------------------------------
// trs_div
// restoring unsigned divider, one quotient bit per cycle, zero divisor gives 0
// ----------------------------------------------------------------------------
`default_nettype none

module trs_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 42
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int CW = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             zero_r, zero_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  // one shift-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      zero_nxt = (den == '0);
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    zero_r <= zero_nxt;
  end

  assign done = done_r;
  assign quo  = zero_r ? '0 : quo_r;

endmodule

`default_nettype wire

[rtl/trs_dp.sv]
// ----------------------------------------------------------------------------
// trs_dp
// byte classification, running counters, shared multiplier and divider
// ----------------------------------------------------------------------------
`default_nettype none

module trs_dp #(
  parameter int MAX_TEXT_BYTES    = trs_pkg::DEF_MAX_TEXT_BYTES,
  parameter int WORD_BUFFER_BYTES = trs_pkg::DEF_WORD_BUFFER_BYTES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire trs_pkg::cmd_t                 cmd,
  output trs_pkg::status_t                   status,
  input  wire logic [7:0]                    text_byte,
  input  wire logic                          byte_present,
  output logic [trs_pkg::OUT_DATA_W-1:0]     out_data
);

  import trs_pkg::*;

  localparam int CAP_I = (MAX_TEXT_BYTES < 2097151) ? MAX_TEXT_BYTES : 2097151;
  localparam logic [CNT_W:0] CAP = (CNT_W + 1)'(CAP_I);
  localparam int LW = $clog2(WORD_BUFFER_BYTES + 1);
  localparam logic [LW-1:0] WB = LW'(WORD_BUFFER_BYTES);

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [LW-1:0] by);
    logic [CNT_W:0] s;
    s = {1'b0, c} + {{(CNT_W + 1 - LW){1'b0}}, by};
    return (s > CAP) ? CAP[CNT_W-1:0] : s[CNT_W-1:0];
  endfunction

  // running counters and word state
  logic [CNT_W-1:0] words_r, words_nxt, bytes_r, bytes_nxt, nonsp_r, nonsp_nxt;
  logic [CNT_W-1:0] nl_r, nl_nxt, sent_r, sent_nxt, syl_r, syl_nxt;
  logic             in_word_r, in_word_nxt, pv_r, pv_nxt, pe_r, pe_nxt, tp_r, tp_nxt;
  logic [LW-1:0]    len_r, len_nxt, wsyl_r, wsyl_nxt;

  // compute registers
  logic [MUL_A_W-1:0]     ww_r, ww_nxt, ys_r, ys_nxt, den_r, den_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [29:0] avglen_r, avgsent_r, grade_r;
  logic [14:0] avgsyl_r;
  logic [31:0] ease_r;
  logic [28:0] fog_r;

  logic       ws, upper, term, vowel, is_e, take_ok;
  logic [7:0] lc;
  logic [LW-1:0] close_syl, len_e, syl_e;
  logic       add_syl, pv_e;
  logic [CNT_W-1:0] s_eff, lines;

  // byte classes
  always_comb begin
    ws      = (text_byte inside {8'd32, [8'd9:8'd13]});
    upper   = (text_byte inside {[8'h41:8'h5A]});
    lc      = upper ? (text_byte + 8'd32) : text_byte;
    vowel   = (lc inside {8'h61, 8'h65, 8'h69, 8'h6F, 8'h75, 8'h79});
    is_e    = (lc == 8'h65);
    term    = (text_byte inside {8'h2E, 8'h21, 8'h3F});
    take_ok = cmd.take && byte_present && (text_byte != 8'd0);
  end

  // syllables credited when the current word closes
  always_comb begin
    close_syl = wsyl_r;
    if ((len_r > LW'(2)) && pe_r && (wsyl_r > LW'(1))) close_syl = wsyl_r - 1'b1;
    if (close_syl == '0) close_syl = LW'(1);
    add_syl = in_word_r && (len_r < WB);
    len_e   = in_word_r ? len_r : '0;
    syl_e   = in_word_r ? wsyl_r : '0;
    pv_e    = in_word_r && pv_r;
  end

  // counter and word-state updates
  always_comb begin
    words_nxt = words_r;  bytes_nxt = bytes_r;  nonsp_nxt = nonsp_r;
    nl_nxt    = nl_r;     sent_nxt  = sent_r;   syl_nxt   = syl_r;
    in_word_nxt = in_word_r;  pv_nxt = pv_r;  pe_nxt = pe_r;  tp_nxt = tp_r;
    len_nxt = len_r;  wsyl_nxt = wsyl_r;
    if (cmd.clear) begin
      words_nxt = '0;  bytes_nxt = '0;  nonsp_nxt = '0;
      nl_nxt    = '0;  sent_nxt  = '0;  syl_nxt   = '0;
      in_word_nxt = 1'b0;  pv_nxt = 1'b0;  pe_nxt = 1'b0;  tp_nxt = 1'b0;
      len_nxt = '0;  wsyl_nxt = '0;
    end else if (cmd.close) begin
      if (add_syl) syl_nxt = sat_add(syl_r, close_syl);
      in_word_nxt = 1'b0;
      if (tp_r) sent_nxt = sat_add(sent_r, LW'(1));
    end else if (take_ok) begin
      bytes_nxt = sat_add(bytes_r, LW'(1));
      if (tp_r && (ws || upper)) sent_nxt = sat_add(sent_r, LW'(1));
      tp_nxt = term;
      if (ws) begin
        if (add_syl) syl_nxt = sat_add(syl_r, close_syl);
        in_word_nxt = 1'b0;
        if (text_byte == 8'd10) nl_nxt = sat_add(nl_r, LW'(1));
      end else begin
        nonsp_nxt = sat_add(nonsp_r, LW'(1));
        if (!in_word_r) words_nxt = sat_add(words_r, LW'(1));
        in_word_nxt = 1'b1;
        len_nxt  = len_e;
        wsyl_nxt = syl_e;
        pv_nxt   = pv_e;
        if (len_e < WB) begin
          if (vowel && !pv_e) wsyl_nxt = syl_e + 1'b1;
          pv_nxt  = vowel;
          len_nxt = len_e + 1'b1;
        end
        pe_nxt = is_e;
      end
    end
  end

  // effective sentence and line counts
  always_comb begin
    if (bytes_r == '0) begin
      s_eff = '0;
      lines = '0;
    end else begin
      s_eff = (sent_r == '0) ? CNT_W'(1) : sent_r;
      lines = nl_r + 1'b1;
    end
  end

  // shared multiplier
  logic [MUL_A_W-1:0]        a_val;
  logic signed [MUL_B_W-1:0] b_val;
  logic signed [MUL_A_W:0]   a_s;
  logic signed [ACC_W:0]     prod;
  logic [CNT_W+1:0]          y2, w3;
  logic                      fog_cond;

  always_comb begin
    case (cmd.uc.a_sel)
      A_W:     a_val = MUL_A_W'(words_r);
      A_S:     a_val = MUL_A_W'(s_eff);
      A_Y:     a_val = MUL_A_W'(syl_r);
      A_L:     a_val = MUL_A_W'(nonsp_r);
      A_WW:    a_val = ww_r;
      A_YS:    a_val = ys_r;
      A_DEN:   a_val = den_r;
      default: a_val = '0;
    endcase
    case (cmd.uc.b_sel)
      B_W:     b_val = {1'b0, words_r};
      B_S:     b_val = {1'b0, s_eff};
      default: b_val = cmd.uc.k;
    endcase
    a_s  = {1'b0, a_val};
    prod = a_s * b_val;
    y2   = {1'b0, syl_r, 1'b0};
    w3   = {2'b0, words_r} + {1'b0, words_r, 1'b0};
    fog_cond = (y2 > w3);
  end

  // divider on the accumulator magnitude
  logic             div_start, div_done, neg;
  logic [ACC_W-1:0] mag, quo, qs;

  assign neg       = acc_r[ACC_W-1];
  assign mag       = neg ? (~acc_r + 1'b1) : acc_r;
  assign div_start = cmd.run && (cmd.uc.kind == K_DIV);
  assign qs        = neg ? (~quo + 1'b1) : quo;

  trs_div #(
    .NUM_W (ACC_W),
    .DEN_W (MUL_A_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mag),
    .den   (a_val),
    .done  (div_done),
    .quo   (quo)
  );

  assign status.div_done = div_done;

  // product and accumulate steps
  always_comb begin
    ww_nxt  = ww_r;
    ys_nxt  = ys_r;
    den_nxt = den_r;
    acc_nxt = acc_r;
    if (cmd.run) begin
      case (cmd.uc.kind)
        K_MUL: begin
          case (cmd.uc.dest)
            D_WW:    ww_nxt  = prod[MUL_A_W-1:0];
            D_YS:    ys_nxt  = prod[MUL_A_W-1:0];
            default: den_nxt = prod[MUL_A_W-1:0];
          endcase
        end
        K_MAC:   acc_nxt = (cmd.uc.clr ? '0 : acc_r) + prod[ACC_W-1:0];
        K_MACF:  if (fog_cond) acc_nxt = acc_r + prod[ACC_W-1:0];
        default: acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= '0;  bytes_r <= '0;  nonsp_r <= '0;
      nl_r    <= '0;  sent_r  <= '0;  syl_r   <= '0;
      in_word_r <= 1'b0;  pv_r <= 1'b0;  pe_r <= 1'b0;  tp_r <= 1'b0;
      len_r <= '0;  wsyl_r <= '0;
    end else begin
      words_r <= words_nxt;  bytes_r <= bytes_nxt;  nonsp_r <= nonsp_nxt;
      nl_r    <= nl_nxt;     sent_r  <= sent_nxt;   syl_r   <= syl_nxt;
      in_word_r <= in_word_nxt;  pv_r <= pv_nxt;  pe_r <= pe_nxt;  tp_r <= tp_nxt;
      len_r <= len_nxt;  wsyl_r <= wsyl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ww_r  <= ww_nxt;
    ys_r  <= ys_nxt;
    den_r <= den_nxt;
    acc_r <= acc_nxt;
  end

  // quotient capture
  always_ff @(posedge clk) begin
    if (div_done && (cmd.uc.kind == K_DIV)) begin
      case (cmd.uc.dest)
        D_AVGLEN:  avglen_r  <= qs[29:0];
        D_AVGSENT: avgsent_r <= qs[29:0];
        D_AVGSYL:  avgsyl_r  <= qs[14:0];
        D_EASE:    ease_r    <= qs[31:0];
        D_GRADE:   grade_r   <= qs[29:0];
        default:   fog_r     <= qs[28:0];
      endcase
    end
  end

  assign out_data = {4'b0, fog_r, grade_r, ease_r, avgsyl_r, avgsent_r, avglen_r,
                     syl_r, s_eff, lines, nonsp_r, bytes_r, words_r};

endmodule

`default_nettype wire

[rtl/trs_ctrl.sv]
// ----------------------------------------------------------------------------
// trs_ctrl
// controller: byte intake, word close, end-of-text program, result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module trs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tlast,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output trs_pkg::cmd_t         cmd,
  input  wire trs_pkg::status_t status
);

  import trs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLOSE = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.uc    = trs_ucode(step_r);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.take = 1'b1;
          if (in_tlast) state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        cmd.close = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        case (cmd.uc.kind)
          K_END: state_nxt = ST_OUT;
          K_DIV: begin
            cmd.run   = 1'b1;
            state_nxt = ST_WAIT;
          end
          default: begin
            cmd.run  = 1'b1;
            step_nxt = step_r + 1'b1;
          end
        endcase
      end
      ST_WAIT: begin
        if (status.div_done) begin
          step_nxt  = step_r + 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/text_readability_statistics_core.sv]
// text bytes: one item per cycle while no text is being finished
// end of text: a word close, 15 multiply and multiply-accumulate steps,
//   6 divisions (64-step restoring divider), then out_tvalid rises
//   once the program reaches its end step
// the next text is taken once the result item has been handed off
// rst_n is synchronous, active low: counters, word state and sequencer clear
// ----------------------------------------------------------------------------
// text_readability_statistics_core
// word, sentence and syllable counts with Flesch, Kincaid and fog indices
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_readability_statistics_core_assert.svh"

module text_readability_statistics_core #(
  parameter int MAX_TEXT_BYTES    = trs_pkg::DEF_MAX_TEXT_BYTES,
  parameter int WORD_BUFFER_BYTES = trs_pkg::DEF_WORD_BUFFER_BYTES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // text_byte
  input  wire logic                          in_tuser,   // byte_present
  input  wire logic                          in_tlast,   // end_of_text
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // words, bytes, nonspace bytes, lines, sentences, syllables,
  // avg_word_len_milli, avg_sentence_len_milli, avg_syllables_milli,
  // reading_ease_milli, grade_level_milli, fog_index_milli
  output logic [trs_pkg::OUT_DATA_W-1:0]     out_tdata
);

  import trs_pkg::*;

  cmd_t    cmd;
  status_t status;

  trs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  trs_dp #(
    .MAX_TEXT_BYTES    (MAX_TEXT_BYTES),
    .WORD_BUFFER_BYTES (WORD_BUFFER_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .text_byte    (in_tdata),
    .byte_present (in_tuser),
    .out_data     (out_tdata)
  );

  // intake is closed while a result is pending
  `TRS_ASSERT_NOW(a_no_intake_with_result, out_tvalid, !in_tready, "intake open with result")
  // the end of a text stops intake in the next cycle
  `TRS_ASSERT_NEXT(a_stop_after_end, in_tvalid && in_tready && in_tlast, !in_tready, "intake after end")

endmodule

`default_nettype wire
